@@ rtl/core/swiw_pkg.sv @@
`default_nettype none

package swiw_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int COORD_BITS      = 8;
   localparam int PIXEL_BITS      = 32;
   localparam int OFFSET_BITS     = 8;
   localparam int TABLE_DEPTH     = 128;
   localparam int TABLE_ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam int MAX_SIZE        = 256;
   localparam int SIZE_BITS       = 9;
   localparam int PHASE_BITS      = 7;
   localparam int IMAGE_ADDR_BITS = 2 * COORD_BITS;
   localparam int IMAGE_DEPTH     = MAX_SIZE * MAX_SIZE;
   // Signed width that holds a coordinate plus any displacement.
   localparam int POS_BITS        = COORD_BITS + 2;

   // Request function codes.
   localparam logic [1:0] FUNC_TABLE_WR = 2'd0;
   localparam logic [1:0] FUNC_PIXEL_WR = 2'd1;
   localparam logic [1:0] FUNC_READ     = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_PHASE = 1'b0;
   localparam logic CSR_SIZE  = 1'b1;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(MAX_SIZE);

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

   typedef enum logic {
      KIND_PIXEL_WR = 1'b0,
      KIND_READ     = 1'b1
   } swiw_kind_type;

   typedef struct packed {
      swiw_kind_type                kind;
      logic [COORD_BITS-1:0]        x;
      logic [COORD_BITS-1:0]        y;
      logic [PIXEL_BITS-1:0]        pixel;
      logic signed [OFFSET_BITS-1:0] dx_raw;
      logic signed [OFFSET_BITS-1:0] dy_raw;
   } swiw_item_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic almost_full;
   } swiw_q_status_type;

endpackage

`default_nettype wire

@@ rtl/core/sine_wave_image_warp_core.sv @@
`default_nettype none

// Wavy flag warp of a square texture held on chip.
//
// Requests enter on start and are taken at a clock edge where busy is low.
// req_func selects the request: 0 writes an entry of the 128-entry signed
// offset table, 1 writes a source pixel at (x, y), 2 reads a warped pixel.
// A warped read looks up a horizontal offset at (y + phase) mod 128, halved
// with floor, and a vertical offset at (x + phase) mod 128, wraps each
// source coordinate once by the size in use and returns the source pixel,
// or zero with rsp_out_of_range set when a coordinate stays outside.
// Only reads produce a response: rsp_strobe is high for one cycle and cannot
// be held off. While busy is low, one request is taken every clock; the
// front reads both offsets in the accepting cycle, and the back may write
// and read the image store at once. Pixel writes and reads pass the queue
// in order, so a read sees all earlier writes. Reset clears phase to 0, the
// size to 256 and empties the pipe; table and image contents are not cleared
// and must be loaded before use. The csr port writes phase (index 0) and
// size (index 1) while idle; the user must ensure this, the block does not.
module sine_wave_image_warp_core
   import swiw_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_func,
   input  wire logic [COORD_BITS-1:0]         req_x_coord,
   input  wire logic [COORD_BITS-1:0]         req_y_coord,
   input  wire logic [TABLE_ADDR_BITS-1:0]    req_table_index,
   input  wire logic signed [OFFSET_BITS-1:0] req_table_value,
   input  wire logic [PIXEL_BITS-1:0]         req_pixel_in,
   output logic                               rsp_strobe,
   output logic [PIXEL_BITS-1:0]              rsp_pixel_out,
   output logic                               rsp_out_of_range,
   input  wire logic                          csr_write_enable,
   input  wire logic                          csr_index,
   input  wire logic [SIZE_BITS-1:0]          csr_write_data
);

   logic [PHASE_BITS-1:0] phase_ff;
   logic [SIZE_BITS-1:0]  size_ff;

   logic              accept;
   logic              f_valid;
   swiw_item_type     f_item;
   swiw_item_type     q_head;
   swiw_q_status_type q_status;
   logic              q_pop;

   // Configuration registers; software, not the block, keeps writes to idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         size_ff  <= SIZE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PHASE: phase_ff <= csr_write_data[PHASE_BITS-1:0];
            CSR_SIZE:  size_ff  <= csr_write_data;
            default:   phase_ff <= phase_ff;
         endcase
      end
   end

   // Busy is high while the queue holds two or more items, keeping room for
   // the request in the front register plus a new one.
   assign busy   = q_status.almost_full;
   assign accept = start && !busy && !reset;

   swiw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_func),
      .x_coord     (req_x_coord),
      .y_coord     (req_y_coord),
      .table_index (req_table_index),
      .table_value (req_table_value),
      .pixel_in    (req_pixel_in),
      .phase       (phase_ff),
      .item_valid  (f_valid),
      .item        (f_item)
   );

   swiw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_item (f_item),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   swiw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head             (q_head),
      .size_in_use      (size_ff),
      .pop              (q_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // Every accepted read request produces a response strobe.
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_READ) |-> ##5 rsp_strobe)
      else $error("read request gave no response");

   // A response is never produced without a read request behind it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_func == FUNC_READ, 5))
      else $error("response without a read request");

   // An out of range response always carries a zero pixel.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_of_range) |-> rsp_pixel_out == '0)
      else $error("out of range response with nonzero pixel");

   // The front never pushes into a full queue that is not draining.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (f_valid && q_status.full) |-> q_pop)
      else $error("queue overflow");

endmodule

`default_nettype wire

@@ rtl/core/swiw_front.sv @@
`default_nettype none

module swiw_front
   import swiw_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [1:0]                    func,
   input  wire logic [COORD_BITS-1:0]         x_coord,
   input  wire logic [COORD_BITS-1:0]         y_coord,
   input  wire logic [TABLE_ADDR_BITS-1:0]    table_index,
   input  wire logic signed [OFFSET_BITS-1:0] table_value,
   input  wire logic [PIXEL_BITS-1:0]         pixel_in,
   input  wire logic [PHASE_BITS-1:0]         phase,
   output logic                               item_valid,
   output swiw_item_type                      item
);

   logic signed [OFFSET_BITS-1:0] offset_mem [TABLE_DEPTH];

   logic                        valid_ff, valid_in;
   swiw_kind_type               kind_ff, kind_in;
   logic [COORD_BITS-1:0]       x_ff, y_ff;
   logic [PIXEL_BITS-1:0]       pixel_ff;
   logic signed [OFFSET_BITS-1:0] dx_raw_ff, dy_raw_ff;
   logic [TABLE_ADDR_BITS-1:0]  dx_addr, dy_addr;

   // The table index wraps naturally in its own width.
   assign dx_addr = y_coord[TABLE_ADDR_BITS-1:0] + phase;
   assign dy_addr = x_coord[TABLE_ADDR_BITS-1:0] + phase;

   // Table writes finish here; pixel writes and reads go on to the back.
   always_comb begin
      valid_in = 1'b0;
      kind_in  = KIND_READ;
      unique case (func)
         FUNC_PIXEL_WR: begin
            valid_in = accept;
            kind_in  = KIND_PIXEL_WR;
         end
         FUNC_READ: begin
            valid_in = accept;
            kind_in  = KIND_READ;
         end
         default: begin
            valid_in = 1'b0;
            kind_in  = KIND_READ;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && func == FUNC_TABLE_WR) begin
         offset_mem[table_index] <= table_value;
      end
      if (accept) begin
         dx_raw_ff <= offset_mem[dx_addr];
         dy_raw_ff <= offset_mem[dy_addr];
         x_ff      <= x_coord;
         y_ff      <= y_coord;
         pixel_ff  <= pixel_in;
         kind_ff   <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign item_valid   = valid_ff;
   assign item.kind    = kind_ff;
   assign item.x       = x_ff;
   assign item.y       = y_ff;
   assign item.pixel   = pixel_ff;
   assign item.dx_raw  = dx_raw_ff;
   assign item.dy_raw  = dy_raw_ff;

endmodule

`default_nettype wire

@@ rtl/core/swiw_queue.sv @@
`default_nettype none

module swiw_queue
   import swiw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire swiw_item_type     push_item,
   input  wire logic              pop,
   output swiw_item_type          head,
   output swiw_q_status_type      status
);

   swiw_item_type q_mem [QUEUE_DEPTH];

   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign do_pop  = pop && count_ff != '0;
   assign do_push = push && (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH) || do_pop);

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign head               = q_mem[rd_ptr_ff];
   assign status.empty       = count_ff == '0;
   assign status.full        = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   // Leaves room for the request that sits in the front register.
   assign status.almost_full = count_ff >= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);

endmodule

`default_nettype wire

@@ rtl/core/swiw_back.sv @@
`default_nettype none

module swiw_back
   import swiw_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire swiw_q_status_type      q_status,
   input  wire swiw_item_type          head,
   input  wire logic [SIZE_BITS-1:0]   size_in_use,
   output logic                        pop,
   output logic                        rsp_strobe,
   output logic [PIXEL_BITS-1:0]       rsp_pixel_out,
   output logic                        rsp_out_of_range
);

   logic [PIXEL_BITS-1:0] image_mem [IMAGE_DEPTH];

   // Stage 1: displaced coordinates before wrapping.
   logic                          s1_valid_ff;
   logic signed [POS_BITS-1:0]    s1_sx_ff, s1_sy_ff;
   logic signed [OFFSET_BITS-1:0] dx_half;
   logic signed [POS_BITS-1:0]    sx_raw, sy_raw;

   // Stage 2: image read data and range flag.
   logic                  s2_valid_ff, s2_bad_ff;
   logic [PIXEL_BITS-1:0] s2_rdata_ff;

   // Stage 3: response registers.
   logic                  s3_strobe_ff;
   logic                  s3_bad_ff;
   logic [PIXEL_BITS-1:0] s3_pixel_ff;

   logic [SIZE_BITS-1:0]        size_eff;
   logic signed [POS_BITS-1:0]  size_s;
   logic signed [POS_BITS-1:0]  sx_w1, sy_w1, sx_w2, sy_w2;
   logic                        bad;

   assign pop = !q_status.empty;

   assign dx_half = head.dx_raw >>> 1;
   assign sx_raw  = $signed({2'b00, head.x})
                  + $signed({{(POS_BITS-OFFSET_BITS){dx_half[OFFSET_BITS-1]}}, dx_half});
   assign sy_raw  = $signed({2'b00, head.y})
                  + $signed({{(POS_BITS-OFFSET_BITS){head.dy_raw[OFFSET_BITS-1]}},
                             head.dy_raw});

   // Sizes above the store saturate.
   assign size_eff = (size_in_use > SIZE_BITS'(MAX_SIZE)) ? SIZE_BITS'(MAX_SIZE)
                                                           : size_in_use;
   assign size_s   = $signed({1'b0, size_eff});

   // Wrap once in each direction, then check what is left.
   always_comb begin
      sx_w1 = (s1_sx_ff < 0) ? s1_sx_ff + size_s : s1_sx_ff;
      sy_w1 = (s1_sy_ff < 0) ? s1_sy_ff + size_s : s1_sy_ff;
      sx_w2 = (sx_w1 >= size_s) ? sx_w1 - size_s : sx_w1;
      sy_w2 = (sy_w1 >= size_s) ? sy_w1 - size_s : sy_w1;
      bad   = sx_w2 < 0 || sx_w2 >= size_s || sy_w2 < 0 || sy_w2 >= size_s;
   end

   always_ff @(posedge clock) begin
      if (pop && head.kind == KIND_PIXEL_WR) begin
         image_mem[{head.y, head.x}] <= head.pixel;
      end
      s2_rdata_ff <= image_mem[{sy_w2[COORD_BITS-1:0], sx_w2[COORD_BITS-1:0]}];
   end

   always_ff @(posedge clock) begin
      s1_sx_ff    <= sx_raw;
      s1_sy_ff    <= sy_raw;
      s2_bad_ff   <= bad;
      s3_bad_ff   <= s2_bad_ff;
      s3_pixel_ff <= s2_bad_ff ? '0 : s2_rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= pop && head.kind == KIND_READ;
         s2_valid_ff  <= s1_valid_ff;
         s3_strobe_ff <= s2_valid_ff;
      end
   end

   assign rsp_strobe       = s3_strobe_ff;
   assign rsp_pixel_out    = s3_pixel_ff;
   assign rsp_out_of_range = s3_bad_ff;

endmodule

`default_nettype wire
